// ===== design/sorted_priority_task_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted priority task queue assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue package
// Sizes, operation and status codes, and the types shared by the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CAPACITY      = 64;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int ID_W          = 16;
   localparam int PRIO_W        = 8;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
   localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(10);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_POP    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_REPRIO = 3'd3,
      OP_RENAME = 3'd4,
      OP_PEEK   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_BAD_PRIO  = 3'd4
   } status_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_INSERT = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [ID_W-1:0]     ins_id;
      logic [PRIO_W-1:0]   ins_prio;
   } chain_ctl_type;

   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     id;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue cell
// One slot of the sorted list: holds an entry, compares it against the key
// and the insert priority, and takes a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire chain_ctl_type   ctl,
   input  wire logic            shift_en,
   input  wire logic [ID_W-1:0] key_id,
   input  wire logic            left_gt,
   input  wire entry_type       left_entry,
   input  wire entry_type       right_entry,
   output entry_type            entry,
   output logic                 gt,
   output logic                 match
);

   logic              valid_ff;
   logic              valid_in;
   logic [ID_W-1:0]   id_ff;
   logic [ID_W-1:0]   id_in;
   logic [PRIO_W-1:0] prio_ff;
   logic [PRIO_W-1:0] prio_in;

   // Local compares seen by the neighbor and the controller
   assign gt    = valid_ff && (prio_ff > ctl.ins_prio);
   assign match = valid_ff && (id_ff == key_id);
   assign entry = '{valid: valid_ff, id: id_ff, prio: prio_ff};

   // Pick the next content: hold, close a gap, or open one for the new entry
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      unique case (ctl.cmd)
         CMD_REMOVE: begin
            if (shift_en) begin
               valid_in = right_entry.valid;
               id_in    = right_entry.id;
               prio_in  = right_entry.prio;
            end
         end
         CMD_INSERT: begin
            if (!gt) begin
               if (left_gt) begin
                  valid_in = 1'b1;
                  id_in    = ctl.ins_id;
                  prio_in  = ctl.ins_prio;
               end else begin
                  valid_in = left_entry.valid;
                  id_in    = left_entry.id;
                  prio_in  = left_entry.prio;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the entry payload
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

`default_nettype wire

// ===== design/spq_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue cell chain
// Row of cells in descending priority order, slot 0 at the head, with the
// match vector and a one-hot read of the selected slot.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_chain
   import spq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire chain_ctl_type       ctl,
   input  wire logic [CAPACITY-1:0] shift_mask,
   input  wire logic [ID_W-1:0]     key_id,
   input  wire logic [CAPACITY-1:0] sel,
   output logic [CAPACITY-1:0]      match,
   output entry_type                head,
   output logic [PRIO_W-1:0]        sel_prio
);

   entry_type             entries [CAPACITY];
   logic [CAPACITY-1:0]   gts;
   localparam entry_type  EMPTY_ENTRY = '{valid: 1'b0, id: '0, prio: '0};

   // Build the row; the head sees an always-greater left neighbor
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_g;

      if (k == 0) begin : g_first
         assign left_e = EMPTY_ENTRY;
         assign left_g = 1'b1;
      end else begin : g_inner
         assign left_e = entries[k-1];
         assign left_g = gts[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_e = EMPTY_ENTRY;
      end else begin : g_mid
         assign right_e = entries[k+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .shift_en    (shift_mask[k]),
         .key_id      (key_id),
         .left_gt     (left_g),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (entries[k]),
         .gt          (gts[k]),
         .match       (match[k])
      );
   end

   assign head = entries[0];

   // Read the priority of the one selected slot
   always_comb begin
      sel_prio = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         sel_prio = sel_prio | (entries[k].prio & {PRIO_W{sel[k]}});
      end
   end

endmodule

`default_nettype wire

// ===== design/sorted_priority_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue core
// Bounded priority queue of id/priority entries kept sorted in a cell chain.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                  Handshake
//   request   req_operation, req_task_id,            start, taken when busy low
//             req_new_id, req_priority_req
//   response  rsp_status, rsp_result_id,             rsp_valid, one cycle
//             rsp_result_priority, rsp_entry_count
//
// State path per request: peek, unused codes and rejects as empty or full
// stay idle; insert and pop pass apply; a missing id passes locate; a bad
// new priority locate and fetch; remove by id locate, fetch and apply;
// reprioritize and rename locate, fetch, reinsert and apply. The id search
// registers the match compare in every cell at start, forms the first-match
// mask (one wide subtract) in locate and reads the found slot in fetch.
// Reset clears the valid flags and count at once; no clearing pass follows.
// The response comes out of a register; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_task_queue_core_assert.svh"

module sorted_priority_task_queue_core
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OP_W-1:0]          req_operation,
   input  wire logic [ID_W-1:0]          req_task_id,
   input  wire logic [ID_W-1:0]          req_new_id,
   input  wire logic [PRIO_W-1:0]        req_priority_req,
   output logic                          rsp_valid,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [ID_W-1:0]               rsp_result_id,
   output logic [PRIO_W-1:0]             rsp_result_priority,
   output logic [ENTRY_COUNT_W-1:0]      rsp_entry_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_FETCH,
      ST_REINSERT,
      ST_APPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   chain_ctl_type        ctl_ff, ctl_in;
   op_type               op_ff, op_in;
   logic [ID_W-1:0]      tid_ff, tid_in;
   logic [ID_W-1:0]      nid_ff, nid_in;
   logic [PRIO_W-1:0]    preq_ff, preq_in;
   logic [CAPACITY-1:0]  match_ff, match_in;
   logic [CAPACITY-1:0]  shift_ff, shift_in;
   logic [CAPACITY-1:0]  sel_ff, sel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]    rsp_prio_ff, rsp_prio_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CAPACITY-1:0]  chain_match;
   entry_type            chain_head;
   logic [PRIO_W-1:0]    chain_sel_prio;
   logic [CAPACITY-1:0]  below_first;
   logic                 is_empty;
   logic                 is_full;

   spq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_ff),
      .shift_mask (shift_ff),
      .key_id     (req_task_id),
      .sel        (sel_ff),
      .match      (chain_match),
      .head       (chain_head),
      .sel_prio   (chain_sel_prio)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= COUNT_W'(CAPACITY));

   // Slots ahead of the first match, from one wide subtract
   assign below_first = (match_ff - CAPACITY'(1)) & ~match_ff;

   // Sequence each request over the chain
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ctl_in        = ctl_ff;
      ctl_in.cmd    = CMD_HOLD;
      op_in         = op_ff;
      tid_in        = tid_ff;
      nid_in        = nid_ff;
      preq_in       = preq_ff;
      match_in      = match_ff;
      shift_in      = shift_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = op_type'(req_operation);
               tid_in        = req_task_id;
               nid_in        = req_new_id;
               preq_in       = req_priority_req;
               match_in      = chain_match;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = '0;
               rsp_prio_in   = '0;
               unique case (op_type'(req_operation))
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = req_task_id;
                     rsp_prio_in  = req_priority_req;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        count_in        = count_ff + COUNT_W'(1);
                        ctl_in.cmd      = CMD_INSERT;
                        ctl_in.ins_id   = req_task_id;
                        ctl_in.ins_prio = req_priority_req;
                        state_in        = ST_APPLY;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_id_in   = chain_head.id;
                        rsp_prio_in = chain_head.prio;
                        if (op_type'(req_operation) == OP_POP) begin
                           count_in   = count_ff - COUNT_W'(1);
                           ctl_in.cmd = CMD_REMOVE;
                           shift_in   = '1;
                           state_in   = ST_APPLY;
                        end
                     end
                  end
                  OP_REMOVE, OP_REPRIO, OP_RENAME: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_LOCATE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOCATE: begin
            // Shift from the first match on, and select only that slot
            shift_in = ~below_first;
            sel_in   = match_ff & ~(match_ff - CAPACITY'(1));
            if (match_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               rsp_id_in     = tid_ff;
               rsp_prio_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_id_in     = tid_ff;
            rsp_prio_in   = chain_sel_prio;
            state_in      = ST_IDLE;
            unique case (op_ff)
               OP_REMOVE: begin
                  count_in   = count_ff - COUNT_W'(1);
                  ctl_in.cmd = CMD_REMOVE;
                  state_in   = ST_APPLY;
               end
               OP_REPRIO: begin
                  if ((preq_ff < PRIO_MIN) || (preq_ff > PRIO_MAX)) begin
                     rsp_status_in = STATUS_BAD_PRIO;
                  end else begin
                     ctl_in.cmd      = CMD_REMOVE;
                     ctl_in.ins_id   = tid_ff;
                     ctl_in.ins_prio = preq_ff;
                     state_in        = ST_REINSERT;
                  end
               end
               OP_RENAME: begin
                  ctl_in.cmd      = CMD_REMOVE;
                  ctl_in.ins_id   = nid_ff;
                  ctl_in.ins_prio = chain_sel_prio;
                  state_in        = ST_REINSERT;
               end
               default: begin
               end
            endcase
         end
         ST_REINSERT: begin
            ctl_in.cmd = CMD_INSERT;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = ENTRY_COUNT_W'(count_in);
   end

   // Hold state, count, chain command and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ctl_ff.cmd   <= CMD_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ctl_ff.cmd   <= ctl_in.cmd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold request fields, search masks and response payload
   always_ff @(posedge clock) begin
      ctl_ff.ins_id   <= ctl_in.ins_id;
      ctl_ff.ins_prio <= ctl_in.ins_prio;
      op_ff           <= op_in;
      tid_ff          <= tid_in;
      nid_ff          <= nid_in;
      preq_ff         <= preq_in;
      match_ff        <= match_in;
      shift_ff        <= shift_in;
      sel_ff          <= sel_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_prio_ff     <= rsp_prio_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_result_priority = rsp_prio_ff;
   assign rsp_entry_count     = rsp_count_ff;

   // Every accepted request is answered at once or still in progress
   `SPQ_ASSERT_NXT(a_request_tracked, start && !busy, busy || rsp_valid, "request dropped")
   // A full rejection reports a full queue
   `SPQ_ASSERT_IMP(a_full_count, rsp_valid && (rsp_status == STATUS_FULL), rsp_entry_count == ENTRY_COUNT_W'(CAPACITY), "full status with room left")
   // An empty response carries no entry and no count
   `SPQ_ASSERT_IMP(a_empty_zero, rsp_valid && (rsp_status == STATUS_EMPTY), (rsp_entry_count == '0) && (rsp_result_id == '0), "empty status with entries")
   // The chain only moves while a request is in progress
   `SPQ_ASSERT_IMP(a_chain_quiet, !busy, ctl_ff.cmd == CMD_HOLD, "chain moved while idle")

endmodule

`default_nettype wire

// ===== bench/spq_response_monitor.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue response monitor
// Watches the request and response channels of the queue core. It keeps its
// own sorted copy of the store and works out the reply to every accepted
// request. Each response is compared field by field with the oldest reply
// still due. The failure count and the number of replies still due go back
// to the testbench top.
// ----------------------------------------------------------------------------

module spq_response_monitor
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [ID_W-1:0]          req_task_id,
   input  logic [ID_W-1:0]          req_new_id,
   input  logic [PRIO_W-1:0]        req_priority_req,
   input  logic                     rsp_valid,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic [ID_W-1:0]          rsp_result_id,
   input  logic [PRIO_W-1:0]        rsp_result_priority,
   input  logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
   output int                       fail_count,
   output int                       pending_count
);

   typedef struct packed {
      status_type                 status;
      logic [ID_W-1:0]            id;
      logic [PRIO_W-1:0]          prio;
      logic [ENTRY_COUNT_W-1:0]   count;
   } queue_reply_type;

   // Shadow of the sorted store, slot 0 is the head
   logic [ID_W-1:0]   held_ids   [CAPACITY];
   logic [PRIO_W-1:0] held_prios [CAPACITY];
   int                held_count;

   queue_reply_type   due_replies [$];
   queue_reply_type   oldest_reply;

   // Drop the entry at pos and close the gap
   function automatic void drop_slot(int pos);
      for (int k = pos; k + 1 < held_count; k++) begin
         held_ids[k]   = held_ids[k + 1];
         held_prios[k] = held_prios[k + 1];
      end
      held_count--;
   endfunction

   // Place ahead of the first entry of equal or lower priority
   function automatic void place_sorted(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      int pos;
      pos = 0;
      while (pos < held_count && held_prios[pos] > prio) pos++;
      for (int k = held_count; k > pos; k--) begin
         held_ids[k]   = held_ids[k - 1];
         held_prios[k] = held_prios[k - 1];
      end
      held_ids[pos]   = id;
      held_prios[pos] = prio;
      held_count++;
   endfunction

   // Apply one request to the shadow store and return the reply it causes
   function automatic queue_reply_type predict_reply(logic [OP_W-1:0] op,
                                                     logic [ID_W-1:0] tid,
                                                     logic [ID_W-1:0] nid,
                                                     logic [PRIO_W-1:0] prio);
      queue_reply_type   reply;
      int                pos;
      logic [PRIO_W-1:0] old_prio;
      reply.status = STATUS_OK;
      reply.id     = '0;
      reply.prio   = '0;
      case (op)
         OP_INSERT: begin
            reply.id   = tid;
            reply.prio = prio;
            if (held_count >= CAPACITY) reply.status = STATUS_FULL;
            else place_sorted(tid, prio);
         end
         OP_POP, OP_PEEK: begin
            if (held_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               reply.id   = held_ids[0];
               reply.prio = held_prios[0];
               if (op == OP_POP) drop_slot(0);
            end
         end
         OP_REMOVE, OP_REPRIO, OP_RENAME: begin
            if (held_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               // Look up the entry nearest the head
               pos = 0;
               while (pos < held_count && held_ids[pos] != tid) pos++;
               reply.id = tid;
               if (pos == held_count) begin
                  reply.status = STATUS_NOT_FOUND;
               end else begin
                  old_prio   = held_prios[pos];
                  reply.prio = old_prio;
                  if (op == OP_REMOVE) begin
                     drop_slot(pos);
                  end else if (op == OP_REPRIO) begin
                     if (prio < PRIO_MIN || prio > PRIO_MAX) begin
                        reply.status = STATUS_BAD_PRIO;
                     end else begin
                        drop_slot(pos);
                        place_sorted(tid, prio);
                     end
                  end else begin
                     drop_slot(pos);
                     place_sorted(nid, old_prio);
                  end
               end
            end
         end
         default: ;
      endcase
      reply.count = ENTRY_COUNT_W'(held_count);
      return reply;
   endfunction

   // Predict on each accepted request, compare each response
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         fail_count = 0;
         due_replies.delete();
      end else begin
         if (start && !busy)
            due_replies.push_back(predict_reply(req_operation, req_task_id,
                                                req_new_id, req_priority_req));
         if (rsp_valid) begin
            if (due_replies.size() == 0) begin
               $error("response with no request outstanding: status %0d id %0h",
                      rsp_status, rsp_result_id);
               fail_count++;
            end else begin
               oldest_reply = due_replies.pop_front();
               if (rsp_status !== oldest_reply.status) begin
                  $error("rsp_status: expected %0d, actual %0d",
                         oldest_reply.status, rsp_status);
                  fail_count++;
               end
               if (rsp_result_id !== oldest_reply.id) begin
                  $error("rsp_result_id: expected %0h, actual %0h",
                         oldest_reply.id, rsp_result_id);
                  fail_count++;
               end
               if (rsp_result_priority !== oldest_reply.prio) begin
                  $error("rsp_result_priority: expected %0d, actual %0d",
                         oldest_reply.prio, rsp_result_priority);
                  fail_count++;
               end
               if (rsp_entry_count !== oldest_reply.count) begin
                  $error("rsp_entry_count: expected %0d, actual %0d",
                         oldest_reply.count, rsp_entry_count);
                  fail_count++;
               end
            end
         end
      end
      pending_count <= due_replies.size();
   end

endmodule

// ===== bench/tb_sorted_priority_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority task queue core testbench
// Drives requests into the queue core: a directed opening through the empty,
// not found, bad priority, duplicate id and unused operation cases, then
// random phases that fill the store to capacity, drain it and mix the two,
// with random gaps on the request side. The response monitor checks every
// reply; this top gives the verdict.
// ----------------------------------------------------------------------------

module tb_sorted_priority_task_queue_core;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int ID_POOL_SIZE = 20;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 185;
   localparam int QUIET_PHASE  = 4;

   // Operation codes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   localparam mix_type PHASE_MIX [PHASE_COUNT] = '{
      MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_FILL,
      MIX_BALANCED, MIX_DRAIN, MIX_BALANCED, MIX_FILL, MIX_DRAIN
   };

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_operation;
   logic [ID_W-1:0]          req_task_id;
   logic [ID_W-1:0]          req_new_id;
   logic [PRIO_W-1:0]        req_priority_req;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [ID_W-1:0]          rsp_result_id;
   logic [PRIO_W-1:0]        rsp_result_priority;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   int                       fail_count;
   int                       pending_count;
   int                       cycle_count;
   bit                       idle_enable;
   logic [ID_W-1:0]          id_pool [ID_POOL_SIZE];

   sorted_priority_task_queue_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_task_id         (req_task_id),
      .req_new_id          (req_new_id),
      .req_priority_req    (req_priority_req),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_priority (rsp_result_priority),
      .rsp_entry_count     (rsp_entry_count)
   );

   spq_response_monitor response_monitor (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_task_id         (req_task_id),
      .req_new_id          (req_new_id),
      .req_priority_req    (req_priority_req),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_priority (rsp_result_priority),
      .rsp_entry_count     (rsp_entry_count),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Idle at random, then hold the request until the core takes it
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid,
                               input logic [ID_W-1:0] nid, input logic [PRIO_W-1:0] prio);
      while (idle_enable && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= op;
      req_task_id      <= tid;
      req_new_id       <= nid;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every reply has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Mostly ids from a small pool so lookups hit and duplicates occur
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
      return ID_W'($urandom);
   endfunction

   // Mostly legal reprioritize values, with ties among them
   function automatic logic [PRIO_W-1:0] pick_priority();
      if ($urandom_range(0, 99) < 70) return PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX));
      return PRIO_W'($urandom);
   endfunction

   function automatic logic [OP_W-1:0] pick_operation(mix_type mix);
      int roll;
      int ins_w;
      int pop_w;
      int rem_w;
      int rep_w;
      int ren_w;
      int peek_w;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin ins_w = 75; pop_w = 5;  rem_w = 4;  rep_w = 5;  ren_w = 5;  end
         MIX_DRAIN: begin ins_w = 15; pop_w = 30; rem_w = 25; rep_w = 10; ren_w = 10; end
         default:   begin ins_w = 35; pop_w = 15; rem_w = 15; rep_w = 13; ren_w = 13; end
      endcase
      peek_w = 4;
      if (roll < ins_w) return OP_INSERT;
      roll -= ins_w;
      if (roll < pop_w) return OP_POP;
      roll -= pop_w;
      if (roll < rem_w) return OP_REMOVE;
      roll -= rem_w;
      if (roll < rep_w) return OP_REPRIO;
      roll -= rep_w;
      if (roll < ren_w) return OP_RENAME;
      roll -= ren_w;
      if (roll < peek_w) return OP_PEEK;
      return roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_INSERT;
      req_task_id      = '0;
      req_new_id       = '0;
      req_priority_req = '0;
      idle_enable      = 1'b1;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Every lookup on an empty queue, then the unused codes
      send_request(OP_POP,    16'h0000, 16'h0000, 8'd0);
      send_request(OP_PEEK,   16'hFFFF, 16'hFFFF, 8'd255);
      send_request(OP_REMOVE, 16'h1234, 16'h0000, 8'd1);
      send_request(OP_REPRIO, 16'h1234, 16'h0000, 8'd5);
      send_request(OP_RENAME, 16'h1234, 16'hABCD, 8'd5);
      send_request(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'd255);
      send_request(OP_SPARE_HI, 16'h5A5A, 16'hA5A5, 8'd128);

      // Inserts at the priority extremes and an equal-priority duplicate
      send_request(OP_INSERT, 16'h0000, 16'hFFFF, 8'd0);
      send_request(OP_INSERT, 16'hFFFF, 16'h0000, 8'd255);
      send_request(OP_INSERT, 16'h1234, 16'h0000, 8'd5);
      send_request(OP_INSERT, 16'h1234, 16'h0000, 8'd5);
      send_request(OP_INSERT, 16'h4321, 16'h0000, 8'd5);
      send_request(OP_PEEK,   16'h0000, 16'h0000, 8'd0);

      // Missing ids, then out-of-range new priorities on a present id
      send_request(OP_REMOVE, 16'h5555, 16'h0000, 8'd3);
      send_request(OP_REPRIO, 16'h5555, 16'h0000, 8'd3);
      send_request(OP_RENAME, 16'h5555, 16'hAAAA, 8'd3);
      send_request(OP_REPRIO, 16'h1234, 16'h0000, 8'd0);
      send_request(OP_REPRIO, 16'h1234, 16'h0000, 8'd11);

      // Legal reprioritize at both ends, rename, remove and pops
      send_request(OP_REPRIO, 16'h1234, 16'h0000, PRIO_MAX);
      send_request(OP_REPRIO, 16'h1234, 16'h0000, PRIO_MIN);
      send_request(OP_RENAME, 16'h1234, 16'hABCD, 8'd0);
      send_request(OP_REMOVE, 16'hFFFF, 16'h0000, 8'd0);
      send_request(OP_POP,    16'h0000, 16'h0000, 8'd0);
      send_request(OP_POP,    16'h0000, 16'h0000, 8'd0);
      wait_for_drain();

      // Random phases; one phase runs without gaps, two end in a full drain
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idle_enable = (phase != QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(pick_operation(PHASE_MIX[phase]), pick_id(), pick_id(),
                         pick_priority());
         if (phase == 2 || phase == 6) wait_for_drain();
      end

      // Let the last replies come out, then give the verdict
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_task_queue_core.f =====
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/spq_chain.sv
design/sorted_priority_task_queue_core.sv
bench/spq_response_monitor.sv
bench/tb_sorted_priority_task_queue_core.sv
